// ===== design/bavf_pkg.sv =====
// Shared widths, reset values and register codes of the altitude and variometer filter.
package bavf_pkg;

    localparam int ALT_W   = 21;
    localparam int AGL_W   = 22;
    localparam int ASL_W   = 21;
    localparam int VARIO_W = 16;

    localparam int ALPHA_W = 16;
    localparam int COUNT_W = 16;
    localparam int GAIN_W  = 8;
    localparam int COEF_W  = 16;

    // Ground sum of up to 65535 samples of 21 bits, signed.
    localparam int GSUM_W = 37;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd8897;
    localparam logic [COUNT_W-1:0] INIT_RST  = 16'd1000;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd20;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_FILTER_ALPHA = 2'd0;
    localparam logic [1:0] REG_INIT_SAMPLES = 2'd1;
    localparam logic [1:0] REG_VARIO_GAIN   = 2'd2;

endpackage

// ===== design/bavf_intf.sv =====
// Valid/ready channel interfaces for altitude samples and filter results.
interface bavf_alt_if;
    logic                              valid;
    logic                              ready;
    logic signed [bavf_pkg::ALT_W-1:0] altitude_cm;

    modport source (output valid, output altitude_cm, input ready);
    modport sink (input valid, input altitude_cm, output ready);
endinterface

interface bavf_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [bavf_pkg::AGL_W-1:0]   agl_cm;
    logic signed [bavf_pkg::ASL_W-1:0]   asl_cm;
    logic signed [bavf_pkg::VARIO_W-1:0] vario_cm_s;
    logic                                calibrating;

    modport source (output valid, output agl_cm, output asl_cm, output vario_cm_s,
                    output calibrating, input ready);
    modport sink (input valid, input agl_cm, input asl_cm, input vario_cm_s,
                  input calibrating, output ready);
endinterface

// ===== design/baro_altitude_vario_filter.sv =====
// Barometric altitude filter with ground reference and variometer, bit-serial datapath.
//
// Usage: one altitude sample (cm) is taken per beat on the sample channel; each sample
// yields exactly one beat on the result channel carrying altitude above ground, filtered
// altitude, filtered vertical speed and a calibration flag. Registers are written over
// the APB port (filter_alpha at 0x0, init_samples at 0x4, vario_gain at 0x8); the user
// must write them only while the block is idle, as the block itself does not enforce it.
// Work per sample: a calibration sample recomputes the ground mean with a restoring
// divider producing one quotient bit per cycle over a 37 + FRAC_BITS bit numerator.
// The rest is shift-add multiplies on one shared multiplier: three after calibration,
// and two (vario gain and vario filter) for a calibration sample, which skips the
// altitude filter. One sample is in work at a time; the next is taken in the cycle
// after the result is registered.
// The result register holds a finished beat while the receiver stalls and the next
// sample is still accepted; its result then waits until the register is free.
// Reset clears the filter state, the ground reference and the sample count, and loads
// the register reset values. The first vertical speed after reset is taken from zero.
module baro_altitude_vario_filter #(
    parameter int FRAC_BITS = bavf_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bavf_alt_if.sink                      sample,
    bavf_res_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bavf_pkg::APB_AW-1:0]   paddr,
    input  logic [bavf_pkg::APB_DW-1:0]   pwdata,
    output logic [bavf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int ALT_W   = bavf_pkg::ALT_W;
    localparam int COEF_W  = bavf_pkg::COEF_W;
    localparam int COUNT_W = bavf_pkg::COUNT_W;
    localparam int GSUM_W  = bavf_pkg::GSUM_W;
    localparam int SW      = FRAC_BITS + 24;          // state width
    localparam int PW      = FRAC_BITS + 40;          // product width
    localparam int NW      = GSUM_W + FRAC_BITS;      // dividend width
    localparam int RW      = SW + 1 - FRAC_BITS;      // rounded integer width
    localparam int CW      = $clog2(NW + 1);

    localparam logic signed [PW-1:0] VCLAMP_HI = PW'(1) <<< (ALT_W - 1 + FRAC_BITS);
    localparam logic signed [PW-1:0] VCLAMP_LO = -VCLAMP_HI;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_LOAD,
        S_DIV,
        S_DIV_END,
        S_MUL,
        S_MUL_END,
        S_AGL,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_ASL,
        OP_VARIO,
        OP_VIIR
    } mul_op_t;

    state_t  state_reg;
    mul_op_t op_reg;

    logic [bavf_pkg::ALPHA_W-1:0] alpha_reg;
    logic [COUNT_W-1:0]           init_reg;
    logic [bavf_pkg::GAIN_W-1:0]  gain_reg;

    logic signed [GSUM_W-1:0] gsum_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic signed [SW-1:0]     asl_reg;
    logic signed [SW-1:0]     prev_agl_reg;
    logic signed [SW-1:0]     fvario_reg;
    logic signed [SW-1:0]     mean_reg;

    logic                     calib_reg;
    logic [CW-1:0]            cnt_reg;
    logic [COEF_W-1:0]        a_reg;
    logic signed [PW-1:0]     d_reg;
    logic signed [PW-1:0]     prod_reg;
    logic [NW-1:0]            num_reg;
    logic [COUNT_W-1:0]       rem_reg;
    logic                     neg_reg;

    logic                                out_valid_reg;
    logic [bavf_pkg::AGL_W-1:0]          agl_out_reg;
    logic [bavf_pkg::ASL_W-1:0]          asl_out_reg;
    logic [bavf_pkg::VARIO_W-1:0]        vario_out_reg;
    logic                                calib_out_reg;

    logic [1:0]               cfg_idx;
    logic                     cfg_write;
    logic signed [SW-1:0]     alt_fx;
    logic                     calib_now;
    logic signed [SW:0]       asl_diff;
    logic signed [SW-1:0]     agl_cur;
    logic signed [SW:0]       agl_diff;
    logic signed [PW-1:0]     vario_c;
    logic signed [SW:0]       viir_diff;
    logic signed [PW-1:0]     prod_rnd;
    logic signed [SW-1:0]     iir_inc;
    logic [COUNT_W:0]         div_trial;
    logic                     div_bit;
    logic [GSUM_W-1:0]        gsum_abs;
    logic signed [RW-1:0]     agl_sat;
    logic signed [RW-1:0]     asl_sat;
    logic signed [RW-1:0]     vario_sat;

    // Round to nearest with halves up, then clamp to a signed field of w bits.
    function automatic logic signed [RW-1:0] sat_fx(input logic signed [SW-1:0] v,
                                                    input int w);
        logic signed [SW:0]   t;
        logic signed [RW-1:0] r;
        int                   ri;
        int                   hi;
        int                   lo;
        t  = {v[SW-1], v} + (SW+1)'(2 ** (FRAC_BITS - 1));
        r  = t[SW:FRAC_BITS];
        ri = int'(r);
        hi = (2 ** (w - 1)) - 1;
        lo = -(2 ** (w - 1));
        if (ri > hi)
        begin
            ri = hi;
        end
        else if (ri < lo)
        begin
            ri = lo;
        end
        return RW'(ri);
    endfunction

    function automatic logic signed [PW-1:0] sext_pw(input logic signed [SW:0] x);
        return {{(PW - SW - 1){x[SW]}}, x};
    endfunction

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            bavf_pkg::REG_FILTER_ALPHA: prdata = bavf_pkg::APB_DW'(alpha_reg);
            bavf_pkg::REG_INIT_SAMPLES: prdata = bavf_pkg::APB_DW'(init_reg);
            bavf_pkg::REG_VARIO_GAIN:   prdata = bavf_pkg::APB_DW'(gain_reg);
            default:                    prdata = '0;
        endcase
    end

    // Datapath terms
    always_comb
    begin
        alt_fx    = {{(SW - ALT_W - FRAC_BITS){sample.altitude_cm[ALT_W-1]}},
                     sample.altitude_cm, {FRAC_BITS{1'b0}}};
        calib_now = count_reg < init_reg;
        asl_diff  = {alt_fx[SW-1], alt_fx} - {asl_reg[SW-1], asl_reg};
        agl_cur   = asl_reg - mean_reg;
        agl_diff  = {agl_cur[SW-1], agl_cur} - {prev_agl_reg[SW-1], prev_agl_reg};

        if (prod_reg > VCLAMP_HI)
        begin
            vario_c = VCLAMP_HI;
        end
        else if (prod_reg < VCLAMP_LO)
        begin
            vario_c = VCLAMP_LO;
        end
        else
        begin
            vario_c = prod_reg;
        end
        viir_diff = {vario_c[SW-1], vario_c[SW-1:0]} - {fvario_reg[SW-1], fvario_reg};

        // floor((a*(x-y) + half) / 2^16) is the increment of the first-order filter.
        prod_rnd  = prod_reg + PW'(2 ** (COEF_W - 1));
        iir_inc   = prod_rnd[PW-1:COEF_W];

        div_trial = {rem_reg, num_reg[NW-1]};
        div_bit   = div_trial >= {1'b0, count_reg};

        gsum_abs  = gsum_reg[GSUM_W-1] ? GSUM_W'(-gsum_reg) : GSUM_W'(gsum_reg);

        agl_sat   = sat_fx(prev_agl_reg, bavf_pkg::AGL_W);
        asl_sat   = sat_fx(asl_reg, bavf_pkg::ASL_W);
        vario_sat = sat_fx(fvario_reg, bavf_pkg::VARIO_W);
    end

    assign sample.ready       = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.agl_cm      = agl_out_reg;
    assign result.asl_cm      = asl_out_reg;
    assign result.vario_cm_s  = vario_out_reg;
    assign result.calibrating = calib_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_ASL;
            alpha_reg     <= bavf_pkg::ALPHA_RST;
            init_reg      <= bavf_pkg::INIT_RST;
            gain_reg      <= bavf_pkg::GAIN_RST;
            gsum_reg      <= '0;
            count_reg     <= '0;
            asl_reg       <= '0;
            prev_agl_reg  <= '0;
            fvario_reg    <= '0;
            mean_reg      <= '0;
            calib_reg     <= 1'b0;
            cnt_reg       <= '0;
            a_reg         <= '0;
            d_reg         <= '0;
            prod_reg      <= '0;
            num_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            agl_out_reg   <= '0;
            asl_out_reg   <= '0;
            vario_out_reg <= '0;
            calib_out_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx)
                    bavf_pkg::REG_FILTER_ALPHA: alpha_reg <= pwdata[bavf_pkg::ALPHA_W-1:0];
                    bavf_pkg::REG_INIT_SAMPLES: init_reg  <= pwdata[COUNT_W-1:0];
                    bavf_pkg::REG_VARIO_GAIN:   gain_reg  <= pwdata[bavf_pkg::GAIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // In the finishing state the result register is handled there.
            if (result.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        calib_reg <= calib_now;
                        if (calib_now)
                        begin
                            gsum_reg  <= gsum_reg + GSUM_W'(sample.altitude_cm);
                            count_reg <= count_reg + COUNT_W'(1);
                            asl_reg   <= alt_fx;
                            state_reg <= S_DIV_LOAD;
                        end
                        else
                        begin
                            d_reg     <= sext_pw(asl_diff);
                            a_reg     <= alpha_reg;
                            prod_reg  <= '0;
                            cnt_reg   <= CW'(COEF_W);
                            op_reg    <= OP_ASL;
                            state_reg <= S_MUL;
                        end
                    end
                end

                S_DIV_LOAD:
                begin
                    num_reg   <= {gsum_abs, {FRAC_BITS{1'b0}}};
                    neg_reg   <= gsum_reg[GSUM_W-1];
                    rem_reg   <= '0;
                    cnt_reg   <= CW'(NW);
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    // Restoring division: one quotient bit per cycle, shifted into the dividend.
                    rem_reg <= div_bit ? COUNT_W'(div_trial - {1'b0, count_reg})
                                       : div_trial[COUNT_W-1:0];
                    num_reg <= {num_reg[NW-2:0], div_bit};
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= S_DIV_END;
                    end
                end

                S_DIV_END:
                begin
                    mean_reg  <= neg_reg ? -$signed(num_reg[SW-1:0])
                                         : $signed(num_reg[SW-1:0]);
                    state_reg <= S_AGL;
                end

                S_MUL:
                begin
                    if (a_reg[0])
                    begin
                        prod_reg <= prod_reg + d_reg;
                    end
                    d_reg   <= d_reg <<< 1;
                    a_reg   <= a_reg >> 1;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= S_MUL_END;
                    end
                end

                S_MUL_END:
                begin
                    unique case (op_reg)
                        OP_ASL:
                        begin
                            asl_reg   <= asl_reg + iir_inc;
                            state_reg <= S_AGL;
                        end
                        OP_VARIO:
                        begin
                            d_reg     <= sext_pw(viir_diff);
                            a_reg     <= alpha_reg;
                            prod_reg  <= '0;
                            cnt_reg   <= CW'(COEF_W);
                            op_reg    <= OP_VIIR;
                            state_reg <= S_MUL;
                        end
                        OP_VIIR:
                        begin
                            fvario_reg <= fvario_reg + iir_inc;
                            state_reg  <= S_FINISH;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_AGL:
                begin
                    prev_agl_reg <= agl_cur;
                    d_reg        <= sext_pw(agl_diff);
                    a_reg        <= COEF_W'(gain_reg);
                    prod_reg     <= '0;
                    cnt_reg      <= CW'(bavf_pkg::GAIN_W);
                    op_reg       <= OP_VARIO;
                    state_reg    <= S_MUL;
                end

                S_FINISH:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        agl_out_reg   <= agl_sat[bavf_pkg::AGL_W-1:0];
                        asl_out_reg   <= asl_sat[bavf_pkg::ASL_W-1:0];
                        vario_out_reg <= vario_sat[bavf_pkg::VARIO_W-1:0];
                        calib_out_reg <= calib_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/bavf_filter_check.sv =====
// Predictor and comparator that watches the sample, result and register ports of the filter.
module bavf_filter_check
    import bavf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bavf_alt_if               sample_mon,
    bavf_res_if               result_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                mismatch_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC       = FRAC_BITS_DEF;
    localparam longint UNIT       = 64'sd1 <<< FRAC;
    localparam longint VARIO_LIM  = 64'sd1 <<< (20 + FRAC);
    localparam longint AGL_MAX    = (64'sd1 <<< (AGL_W - 1)) - 1;
    localparam longint ASL_MAX    = (64'sd1 <<< (ASL_W - 1)) - 1;
    localparam longint VARIO_MAX  = (64'sd1 <<< (VARIO_W - 1)) - 1;

    typedef struct packed {
        logic signed [AGL_W-1:0]   agl;
        logic signed [ASL_W-1:0]   asl;
        logic signed [VARIO_W-1:0] vario;
        logic                      calibrating;
    } alt_fix_t;

    // Register copies, as last written over the bus.
    logic [ALPHA_W-1:0] alpha;
    logic [COUNT_W-1:0] init_cnt;
    logic [GAIN_W-1:0]  gain;

    // Filter state: ground sum (cm) and count, then values fixed point with FRAC fractional bits.
    longint             ground_sum;
    logic [COUNT_W-1:0] ground_count;
    longint             filt_asl;
    longint             prev_agl;
    longint             vario_state;

    alt_fix_t awaited_fixes[$];
    alt_fix_t want;

    function automatic longint iir_update(input longint x, input longint y);
        longint a;
        longint b;
        a = longint'({48'd0, alpha});
        b = (64'sd1 <<< COEF_W) - a;
        return (a * x + b * y + (64'sd1 <<< (COEF_W - 1))) >>> COEF_W;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round to nearest whole centimetre, halves upwards.
    function automatic longint round_cm(input longint v);
        return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic alt_fix_t filter_step(input logic signed [ALT_W-1:0] alt_in);
        longint   alt_fx;
        longint   mean_fx;
        longint   agl_fx;
        longint   vario_fx;
        logic     calib;
        alt_fix_t fix;
        alt_fx = longint'(alt_in) * UNIT;
        calib  = ground_count < init_cnt;
        if (calib)
        begin
            ground_sum   = ground_sum + longint'(alt_in);
            ground_count = ground_count + COUNT_W'(1);
            filt_asl     = alt_fx;
        end
        else
        begin
            filt_asl = iir_update(alt_fx, filt_asl);
        end
        // With no ground samples at all the reference is taken as zero.
        if (ground_count != 0)
            mean_fx = (ground_sum * UNIT) / longint'({48'd0, ground_count});
        else
            mean_fx = 0;
        agl_fx      = filt_asl - mean_fx;
        vario_fx    = (agl_fx - prev_agl) * longint'({56'd0, gain});
        vario_fx    = clamp(vario_fx, -VARIO_LIM, VARIO_LIM);
        vario_state = iir_update(vario_fx, vario_state);
        prev_agl    = agl_fx;
        fix.agl         = AGL_W'(clamp(round_cm(agl_fx), -AGL_MAX - 1, AGL_MAX));
        fix.asl         = ASL_W'(clamp(round_cm(filt_asl), -ASL_MAX - 1, ASL_MAX));
        fix.vario       = VARIO_W'(clamp(round_cm(vario_state), -VARIO_MAX - 1, VARIO_MAX));
        fix.calibrating = calib;
        return fix;
    endfunction

    task automatic check_field(input string label, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha          = ALPHA_RST;
            init_cnt       = INIT_RST;
            gain           = GAIN_RST;
            ground_sum     = 0;
            ground_count   = '0;
            filt_asl       = 0;
            prev_agl       = 0;
            vario_state    = 0;
            mismatch_count = 0;
            awaited_fixes.delete();
            outstanding   <= 0;
        end
        else
        begin
            // The result beat is older than any sample taken at the same edge.
            if (result_mon.valid && result_mon.ready)
            begin
                if (awaited_fixes.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected, agl_cm %0d",
                             $time, result_mon.agl_cm);
                end
                else
                begin
                    want = awaited_fixes.pop_front();
                    check_field("agl_cm", want.agl, result_mon.agl_cm);
                    check_field("asl_cm", want.asl, result_mon.asl_cm);
                    check_field("vario_cm_s", want.vario, result_mon.vario_cm_s);
                    check_field("calibrating", want.calibrating, result_mon.calibrating);
                end
            end
            if (sample_mon.valid && sample_mon.ready)
                awaited_fixes.push_back(filter_step(sample_mon.altitude_cm));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_FILTER_ALPHA: alpha    = pwdata[ALPHA_W-1:0];
                    REG_INIT_SAMPLES: init_cnt = pwdata[COUNT_W-1:0];
                    REG_VARIO_GAIN:   gain     = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            outstanding <= awaited_fixes.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the filter testbench: clock, reset, register writes, sample and result traffic, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bavf_pkg::*;

    localparam int MAX_CYCLES    = 1_000_000;
    localparam int HOLD_CYCLES   = 2000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 50;
    localparam int ALT_MAX       = (1 << (ALT_W - 1)) - 1;
    localparam int ALT_MIN       = -(1 << (ALT_W - 1));

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int in_flight;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int walk_alt;
    int cycle_count;

    bavf_alt_if alt_ch();
    bavf_res_if res_ch();

    baro_altitude_vario_filter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (alt_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bavf_filter_check u_fix_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_mon     (alt_ch),
        .result_mon     (res_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (fail_count),
        .outstanding    (in_flight)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off when the stimulus asks for it.
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            default:
            begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
        endcase
    endtask

    task automatic apb_write(input logic [1:0] reg_code, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_code, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_alt(input logic signed [ALT_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            alt_ch.valid <= 1'b0;
            @(negedge clk);
        end
        alt_ch.valid       <= 1'b1;
        alt_ch.altitude_cm <= v;
        @(posedge clk);
        while (!alt_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        alt_ch.valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly a slow random walk, so that the vario stays in range, with jumps and noise.
    function automatic logic signed [ALT_W-1:0] next_altitude();
        int                      pick;
        logic signed [ALT_W-1:0] noise;
        pick  = $urandom_range(0, 99);
        noise = ALT_W'($urandom);
        if (pick < 70)
            walk_alt += int'($urandom_range(0, 400)) - 200;
        else if (pick < 80)
            walk_alt += int'($urandom_range(0, 16384)) - 8192;
        else if (pick < 95)
            walk_alt = noise;
        else
            walk_alt = pick[0] ? ALT_MAX : ALT_MIN;
        if (walk_alt > ALT_MAX)
            walk_alt = ALT_MAX;
        if (walk_alt < ALT_MIN)
            walk_alt = ALT_MIN;
        return walk_alt[ALT_W-1:0];
    endfunction

    initial
    begin : stimulus
        int                 ph;
        int                 k;
        logic [ALPHA_W-1:0] alpha_v;
        logic [COUNT_W-1:0] init_v;
        logic [GAIN_W-1:0]  gain_v;

        alt_ch.valid       = 1'b0;
        alt_ch.altitude_cm = '0;
        res_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        rst_n              = 1'b0;
        hold_req           = 0;
        hold_seen          = 0;
        hold_left          = 0;
        walk_alt           = 0;
        cycle_count        = 0;
        set_idle(IDLE_NONE);
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // No ground samples at all: the reference stays at zero, reset weights apply.
        apb_write(REG_INIT_SAMPLES, 0);
        send_alt(0);
        send_alt(ALT_MAX);
        send_alt(ALT_MIN);
        send_alt(-1);
        drain();

        // Short calibration on extreme samples, then full-scale swings that clamp the vario.
        apb_write(REG_INIT_SAMPLES, 4);
        apb_write(REG_FILTER_ALPHA, 65535);
        apb_write(REG_VARIO_GAIN, 255);
        send_alt(ALT_MAX);
        send_alt(ALT_MAX);
        send_alt(ALT_MIN);
        send_alt(ALT_MIN);
        send_alt(ALT_MAX);
        send_alt(ALT_MIN);
        send_alt(ALT_MAX);
        send_alt(0);
        drain();

        // A zero weight holds both filtered values.
        apb_write(REG_FILTER_ALPHA, 0);
        send_alt(12345);
        send_alt(-777);
        drain();

        // Raising the sample target resumes calibration; lowering it ends it at once.
        apb_write(REG_FILTER_ALPHA, 1);
        apb_write(REG_INIT_SAMPLES, 65535);
        send_alt(100);
        send_alt(-100);
        send_alt(5);
        drain();
        apb_write(REG_INIT_SAMPLES, 1);
        apb_write(REG_VARIO_GAIN, 1);
        apb_write(REG_FILTER_ALPHA, 32768);
        send_alt(0);
        send_alt(1);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       alpha_v = 1;
                1:       alpha_v = 65535;
                2:       alpha_v = 0;
                default: alpha_v = ALPHA_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 7))
                0:       init_v = 1;
                1:       init_v = 65535;
                default: init_v = COUNT_W'($urandom_range(2, 150));
            endcase
            case ($urandom_range(0, 5))
                0:       gain_v = 0;
                1:       gain_v = 1;
                2:       gain_v = 255;
                default: gain_v = GAIN_W'($urandom_range(1, 255));
            endcase
            apb_write(REG_FILTER_ALPHA, alpha_v);
            apb_write(REG_INIT_SAMPLES, init_v);
            apb_write(REG_VARIO_GAIN, gain_v);
            set_idle(idle_mode_e'(ph % 4));
            // The sender keeps offering beats through the hold-off, so the block backs up.
            if (ph == 4)
                hold_req++;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 10 && k == PHASE_ITEMS / 2)
                    drain();
                send_alt(next_altitude());
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/bavf_pkg.sv
design/bavf_intf.sv
design/baro_altitude_vario_filter.sv
verif/bavf_filter_check.sv
verif/testbench.sv
